// ===== hw/rtl/trg_pkg.sv =====
// ----------------------------------------------------------------------------
// trg_pkg
// Shared types and constants of the triangular random generator.
// ----------------------------------------------------------------------------
package trg_pkg;

	// congruential generator x = x * LCG_MULT + LCG_INC
	localparam logic [31:0] LCG_MULT   = 32'd69069;
	localparam logic [31:0] LCG_INC    = 32'd1;
	localparam logic [31:0] SEED_RESET = 32'd2345236;

	// register reset values, Q.8
	localparam logic signed [23:0] LOWER_RESET = 24'sd0;
	localparam logic signed [23:0] UPPER_RESET = 24'sd1280;
	localparam logic signed [23:0] PEAK_RESET  = 24'sd1024;

	// register indexes
	localparam logic [1:0] REG_LOWER = 2'd0;
	localparam logic [1:0] REG_UPPER = 2'd1;
	localparam logic [1:0] REG_PEAK  = 2'd2;
	localparam logic [1:0] REG_SEED  = 2'd3;

	// one result bit of the square root per step
	localparam int ROOT_STEPS = 16;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW1,
		ST_SIDE_MUL,
		ST_SIDE_CMP,
		ST_ROOT,
		ST_SCALE_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic draw1;
		logic side_mul;
		logic side_cmp;
		logic root_step;
		logic scale_mul;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic root_last;
	} status_t;

	typedef struct packed {
		logic signed [23:0] lower_bound;
		logic signed [23:0] upper_bound;
		logic signed [23:0] peak;
		logic               seed_load;
		logic [31:0]        seed;
	} cfg_t;

endpackage

// ===== hw/rtl/trg_ctrl.sv =====
// ----------------------------------------------------------------------------
// trg_ctrl
// Sequencer of one sample: two draws, side test, square root, scaling.
// ----------------------------------------------------------------------------
module trg_ctrl import trg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    request,
	output logic    in_stall,
	input  logic    out_stall,
	output logic    out_valid,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && request) begin
					state_d = ST_DRAW1;
				end
			end
			ST_DRAW1: begin
				cmd.draw1 = 1'b1;
				state_d   = ST_SIDE_MUL;
			end
			ST_SIDE_MUL: begin
				cmd.side_mul = 1'b1;
				state_d      = ST_SIDE_CMP;
			end
			ST_SIDE_CMP: begin
				cmd.side_cmp = 1'b1;
				state_d      = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (status.root_last) begin
					state_d = ST_SCALE_MUL;
				end
			end
			ST_SCALE_MUL: begin
				cmd.scale_mul = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to be free
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/trg_datapath.sv =====
// ----------------------------------------------------------------------------
// trg_datapath
// Generator state, side test, bit-serial square root, scaling, output register.
// ----------------------------------------------------------------------------
module trg_datapath import trg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output status_t            status,
	output logic signed [31:0] sample,
	output logic               upper_side
);

	logic [31:0]        gen_q;
	logic [31:0]        gen_next;
	logic signed [57:0] side_prod_q;
	logic               upper_q;
	logic [31:0]        rad_q;
	logic [17:0]        rem_q;
	logic [15:0]        root_q;
	logic [STEP_W-1:0]  step_q;
	logic signed [42:0] scale_prod_q;
	logic signed [31:0] sample_q;
	logic               upper_side_q;

	logic signed [24:0] span;
	logic signed [24:0] peak_off;
	logic signed [57:0] side_rhs;
	logic [19:0]        rem_shift;
	logic [19:0]        trial;
	logic [16:0]        frac;
	logic signed [24:0] slope;
	logic signed [43:0] acc;
	logic signed [35:0] acc_q8;
	logic signed [31:0] sat;

	assign gen_next = gen_q * LCG_MULT + LCG_INC;

	assign span     = 25'(cfg.upper_bound) - 25'(cfg.lower_bound);
	assign peak_off = 25'(cfg.peak) - 25'(cfg.lower_bound);
	assign side_rhs = {peak_off[24], peak_off, 32'd0};

	// one digit of the restoring square root
	assign rem_shift = {rem_q, rad_q[31:30]};
	assign trial     = {2'b00, root_q, 2'b01};

	assign frac  = 17'h10000 - {1'b0, root_q};
	assign slope = upper_q ? (25'(cfg.upper_bound) - 25'(cfg.peak)) : peak_off;

	always_comb begin
		if (upper_q) begin
			acc = 44'($signed({cfg.peak, 16'd0})) + 44'(scale_prod_q);
		end else begin
			acc = 44'($signed({cfg.peak, 16'd0})) - 44'(scale_prod_q);
		end
		acc_q8 = 36'(acc >>> 8);
		if (acc_q8 > 36'sh07FFFFFFF) begin
			sat = 32'sh7FFFFFFF;
		end else if (acc_q8 < -36'sh080000000) begin
			sat = 32'sh80000000;
		end else begin
			sat = acc_q8[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q  <= SEED_RESET;
			step_q <= '0;
		end else begin
			if (cfg.seed_load) begin
				gen_q <= cfg.seed;
			end else if (cmd.draw1 || cmd.side_cmp) begin
				gen_q <= gen_next;
			end
			if (cmd.side_cmp) begin
				step_q <= '0;
			end else if (cmd.root_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.side_mul) begin
			side_prod_q <= 58'($signed({1'b0, gen_q})) * 58'(span);
		end
		if (cmd.side_cmp) begin
			upper_q <= side_prod_q >= side_rhs;
			rad_q   <= gen_next;
			rem_q   <= '0;
			root_q  <= '0;
		end
		if (cmd.root_step) begin
			rad_q <= {rad_q[29:0], 2'b00};
			if (rem_shift >= trial) begin
				rem_q  <= 18'(rem_shift - trial);
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[17:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
		if (cmd.scale_mul) begin
			scale_prod_q <= 43'(slope) * 43'($signed({1'b0, frac}));
		end
		if (cmd.load_out) begin
			sample_q     <= sat;
			upper_side_q <= upper_q;
		end
	end

	assign status.root_last = (step_q == STEP_W'(ROOT_STEPS - 1));
	assign sample           = sample_q;
	assign upper_side       = upper_side_q;

endmodule

// ===== hw/rtl/triangular_random_generator.sv =====
// ----------------------------------------------------------------------------
// triangular_random_generator
// Draws one triangular-distributed Q.16 sample per request from a 32-bit
// congruential generator, a bit-serial square root and two multiplies.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    request
// out      output     out_valid / out_stall  sample, upper_side
// cfg      input      cfg_write              cfg_addr, cfg_data
//
// a request transfer reaches the output register through two generator draws,
// the side multiply and compare, 16 steps of the one-bit-per-step square root,
// the scaling multiply and the final add. the block returns to idle after the
// load and takes no new request before then. a request of 0 is taken and dropped.
// reset loads the register reset values and the seed into the generator.
// a full output register stalls only the final step; a new request is taken
// while a finished sample waits.
//
module triangular_random_generator import trg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               request,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sample,
	output logic               upper_side,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_addr,
	input  logic [31:0]        cfg_data
);

	logic signed [23:0] lower_bound_q;
	logic signed [23:0] upper_bound_q;
	logic signed [23:0] peak_q;
	cfg_t               cfg;
	cmd_t               cmd;
	status_t            status;

	// configuration registers, to be written only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_bound_q <= LOWER_RESET;
			upper_bound_q <= UPPER_RESET;
			peak_q        <= PEAK_RESET;
		end else if (cfg_write) begin
			case (cfg_addr)
				REG_LOWER: lower_bound_q <= cfg_data[23:0];
				REG_UPPER: upper_bound_q <= cfg_data[23:0];
				REG_PEAK:  peak_q        <= cfg_data[23:0];
				default: begin
					// seed goes straight into the generator state
				end
			endcase
		end
	end

	assign cfg.lower_bound = lower_bound_q;
	assign cfg.upper_bound = upper_bound_q;
	assign cfg.peak        = peak_q;
	assign cfg.seed_load   = cfg_write && (cfg_addr == REG_SEED);
	assign cfg.seed        = cfg_data;

	// sequencer
	trg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.request   (request),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	trg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.sample     (sample),
		.upper_side (upper_side)
	);

`ifndef ASSERT_OFF
	// an accepted request keeps the block busy on the next cycle
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && request) |=> in_stall)
		else $error("request accepted but block not busy");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("output register overwritten while stalled");

	// a new result appears only after the final step loaded it
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("output valid without a load");
`endif

endmodule

// ===== bench/triangular_random_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangular_random_generator_tb
// Drives sample requests through the generator under changing distribution
// shapes and seeds, predicts every sample and side bit, and checks each
// output transfer in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module triangular_random_generator_tb;
	import trg_pkg::*;

	// settling time after the last sample, with slack over the longest request
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_REQUESTS = 250;

	typedef struct {
		logic signed [31:0] sample;
		logic               upper_side;
	} tri_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               request = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] sample;
	logic               upper_side;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_addr = REG_LOWER;
	logic [31:0]        cfg_data = '0;

	// mirror of the block: distribution shape and generator state
	logic signed [23:0] lo_q8;
	logic signed [23:0] hi_q8;
	logic signed [23:0] mode_q8;
	logic [31:0]        lcg_x;

	// samples predicted at request time, waiting for their output transfer
	tri_result_t pending_samples[$];

	int mismatches = 0;
	int samples_requested = 0;
	int upper_seen = 0;
	int lower_seen = 0;
	int shapes_loaded = 0;
	int in_gap_pct = 0;
	int out_stall_pct = 0;

	triangular_random_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.request   (request),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample),
		.upper_side(upper_side),
		.cfg_write (cfg_write),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor of the square root, one result bit per pass from the top
	function automatic logic [15:0] root_floor(input logic [31:0] v);
		logic [15:0] r;
		logic [31:0] trial;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = {16'd0, r | (16'd1 << b)};
			if (trial * trial <= v)
				r = r | (16'd1 << b);
		end
		return r;
	endfunction

	// advance the generator twice and form the triangular sample
	function automatic tri_result_t draw_triangular();
		logic [31:0] u1;
		logic [31:0] u2;
		longint lo, hi, md, lhs, rhs, frac, acc;
		tri_result_t res;
		lo = lo_q8;
		hi = hi_q8;
		md = mode_q8;
		lcg_x = lcg_x * LCG_MULT + LCG_INC;
		u1 = lcg_x;
		lcg_x = lcg_x * LCG_MULT + LCG_INC;
		u2 = lcg_x;
		// side test: u1 * (hi - lo) >= (peak - lo) * 2^32
		lhs = longint'({32'd0, u1}) * (hi - lo);
		rhs = (md - lo) <<< 32;
		res.upper_side = (lhs >= rhs);
		frac = 65536 - longint'({48'd0, root_floor(u2)});
		// exact value carries 24 fraction bits
		acc = md * 65536;
		if (res.upper_side)
			acc = acc + (hi - md) * frac;
		else
			acc = acc - (md - lo) * frac;
		// arithmetic shift drops 8 bits toward minus infinity
		acc = acc >>> 8;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		res.sample = acc[31:0];
		return res;
	endfunction

	// one request transfer, with an optional random gap ahead of it
	task automatic send_request(input logic req);
		if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		request <= req;
		do @(posedge clk); while (in_stall);
		// a zero request is taken and dropped, the generator holds
		if (req) begin
			pending_samples.push_back(draw_triangular());
			samples_requested++;
		end
	endtask

	// stop sending and wait for every predicted sample, then let the block settle
	task automatic drain_samples();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// single register write, the mirror follows at once since the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_LOWER: lo_q8 = data[23:0];
			REG_UPPER: hi_q8 = data[23:0];
			REG_PEAK:  mode_q8 = data[23:0];
			REG_SEED:  lcg_x = data;
			default: ;
		endcase
	endtask

	// load a shape; the unused top byte gets random bits, the block ignores it
	task automatic set_shape(input logic signed [23:0] lo, input logic signed [23:0] hi,
			input logic signed [23:0] md);
		logic [7:0] pad_lo, pad_hi, pad_md;
		pad_lo = 8'($urandom);
		pad_hi = 8'($urandom);
		pad_md = 8'($urandom);
		drain_samples();
		write_reg(REG_LOWER, {pad_lo, lo});
		write_reg(REG_UPPER, {pad_hi, hi});
		write_reg(REG_PEAK, {pad_md, md});
		shapes_loaded++;
	endtask

	task automatic set_seed(input logic [31:0] value);
		drain_samples();
		write_reg(REG_SEED, value);
	endtask

	task automatic burst_requests(input int count);
		repeat (count) send_request(1'b1);
	endtask

	// reset values of the shape and the generator
	task automatic test_reset_state();
		in_gap_pct = 20;
		out_stall_pct = 10;
		burst_requests(2);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
	endtask

	task automatic test_seed_extremes();
		set_seed(32'h0000_0000);
		burst_requests(2);
		set_seed(32'hFFFF_FFFF);
		burst_requests(2);
	endtask

	// widest range, peak on either bound, collapsed, inverted, peak outside
	task automatic test_shape_extremes();
		set_shape(-24'sd8388608, 24'sd8388607, 24'sd0);
		burst_requests(2);
		set_shape(-24'sd8388608, 24'sd8388607, -24'sd8388608);
		burst_requests(2);
		set_shape(-24'sd8388608, 24'sd8388607, 24'sd8388607);
		burst_requests(2);
		set_shape(24'sd300, 24'sd300, 24'sd300);
		burst_requests(2);
		set_shape(24'sd8388607, -24'sd8388608, 24'sd0);
		burst_requests(2);
		set_shape(-24'sd1000, 24'sd1000, 24'sd8388607);
		burst_requests(2);
	endtask

	// mostly ordered shapes, some narrow, some extreme, some arbitrary
	task automatic pick_random_shape();
		logic signed [23:0] a, b, c, t;
		int kind;
		a = 24'($urandom);
		b = 24'($urandom);
		c = 24'($urandom);
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			a = -24'sd8388608;
			b = 24'sd8388607;
		end else if (kind <= 3) begin
			b = a + 24'($urandom_range(0, 600));
			c = a + 24'($urandom_range(0, 600));
		end
		if (kind != 1) begin
			// order so that lower <= peak <= upper
			if (a > b) begin t = a; a = b; b = t; end
			if (c < a) begin t = c; c = a; a = t; end
			if (c > b) begin t = c; c = b; b = t; end
		end
		set_shape(a, b, c);
	endtask

	// pick new idling rates, zero comes up often enough for clean stretches
	task automatic reroll_idling();
		int gap_choice[4] = '{0, 10, 30, 60};
		int stall_choice[4] = '{0, 3, 10, 25};
		in_gap_pct = gap_choice[$urandom_range(0, 3)];
		out_stall_pct = stall_choice[$urandom_range(0, 3)];
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick_random_shape();
			set_seed($urandom);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (phase == RANDOM_PHASES - 1) begin
					// closing stretch runs at full rate
					in_gap_pct = 0;
					out_stall_pct = 0;
				end else if (n % 50 == 0) begin
					reroll_idling();
				end
				// hold off until every sample is out, once mid-run
				if (phase == 2 && n == PHASE_REQUESTS / 2)
					drain_samples();
				// stray zero requests as noise
				if ($urandom_range(0, 19) == 0)
					send_request(1'b0);
				send_request(1'b1);
			end
		end
	endtask

	initial begin : downstream_stalls
		forever begin
			@(negedge clk);
			if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// each output transfer against the oldest prediction
	always @(posedge clk) begin : check_samples
		tri_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: sample %0d upper_side %0b",
						sample, upper_side);
			end else begin
				want = pending_samples.pop_front();
				if (sample !== want.sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample mismatch: expected %0d got %0d",
							want.sample, sample);
				end
				if (upper_side !== want.upper_side) begin
					mismatches++;
					if (mismatches <= 10)
						$display("upper_side mismatch: expected %0b got %0b",
							want.upper_side, upper_side);
				end
				if (want.upper_side)
					upper_seen++;
				else
					lower_seen++;
			end
		end
	end

	initial begin : run_tests
		lo_q8 = LOWER_RESET;
		hi_q8 = UPPER_RESET;
		mode_q8 = PEAK_RESET;
		lcg_x = SEED_RESET;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_seed_extremes();
		test_shape_extremes();
		test_random_phases();
		drain_samples();

		$display("covered %0d samples (%0d upper side, %0d lower side) over %0d shapes",
			samples_requested, upper_seen, lower_seen, shapes_loaded);
		$display("seeds, extreme and inverted bounds, zero requests, idling on both sides");
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// generous ceiling, far above the slowest passing run
	initial begin : run_limit
		#10_000_000;
		$display("run limit reached with %0d samples outstanding", pending_samples.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
